// ----- hw/rtl/cvfr_pkg.sv -----
package cvfr_pkg;

    // Default number of table entries.
    localparam int TYPE_COUNT_DEF = 16;

    // Frame layout.
    localparam int          FRAME_BYTES     = 6;
    localparam logic [2:0]  POS_TYPE        = 3'd4;
    localparam logic [2:0]  POS_CHECK       = 3'(FRAME_BYTES - 1);
    localparam logic [31:0] CHECK_FAIL_WORD = 32'hFEFE_FEFE;
    localparam logic [7:0]  RUN_MAX         = 8'hFF;

    // Request opcodes.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Result kinds.
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // Frame status codes.
    localparam logic [1:0] ST_STORED = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_CHECK  = 2'd2;

    // Completion report of one frame.
    typedef struct packed {
        logic        done;
        logic [1:0]  status;
        logic [7:0]  frame_type;
        logic [15:0] stored_value;
        logic [31:0] error_word;
        logic [7:0]  run_count;
    } frame_rpt_t;

    // Table write issued by the frame logic.
    typedef struct packed {
        logic        en;
        logic [7:0]  entry;
        logic [15:0] data;
    } table_wr_t;

endpackage

// ----- hw/rtl/cvfr_frame.sv -----
module cvfr_frame #(
    parameter int TYPE_COUNT = cvfr_pkg::TYPE_COUNT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 byte_en,
    input  logic [7:0]           rx_byte,
    output cvfr_pkg::frame_rpt_t rpt,
    output cvfr_pkg::table_wr_t  wr,
    output logic [31:0]          error_hold
);
    import cvfr_pkg::*;

    logic [2:0]  pos_reg, pos_next;
    logic [31:0] shift_reg, shift_next;
    logic [7:0]  xor_reg, xor_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] err_reg, err_next;
    logic [7:0]  run_reg, run_next;
    logic        check_ok;
    logic        in_range;

    assign check_ok   = (xor_reg == rx_byte);
    assign in_range   = ({1'b0, type_reg} < 9'(TYPE_COUNT));
    assign error_hold = err_reg;

    // Byte assembly and frame completion.
    always_comb begin
        pos_next   = pos_reg;
        shift_next = shift_reg;
        xor_next   = xor_reg;
        type_next  = type_reg;
        err_next   = err_reg;
        run_next   = run_reg;
        rpt        = '0;
        wr         = '0;
        if (byte_en) begin
            if (pos_reg < POS_TYPE) begin
                shift_next = {shift_reg[23:0], rx_byte};
                xor_next   = xor_reg ^ rx_byte;
                pos_next   = pos_reg + 3'd1;
            end else if (pos_reg == POS_TYPE) begin
                type_next = rx_byte;
                xor_next  = xor_reg ^ rx_byte;
                pos_next  = pos_reg + 3'd1;
            end else begin
                pos_next            = '0;
                shift_next          = '0;
                xor_next            = '0;
                type_next           = '0;
                rpt.done            = 1'b1;
                rpt.frame_type      = type_reg;
                if (check_ok && in_range) begin
                    // Good frame: store the low half and extend the run.
                    wr.en            = 1'b1;
                    wr.entry         = type_reg;
                    wr.data          = shift_reg[15:0];
                    if (run_reg != RUN_MAX) begin
                        run_next = run_reg + 8'd1;
                    end
                    rpt.status       = ST_STORED;
                    rpt.stored_value = shift_reg[15:0];
                    rpt.error_word   = err_reg;
                end else begin
                    // Bad frame: update the error word and close the run.
                    if (check_ok) begin
                        err_next   = shift_reg;
                        rpt.status = ST_RANGE;
                    end else begin
                        err_next   = CHECK_FAIL_WORD;
                        rpt.status = ST_CHECK;
                    end
                    rpt.error_word = err_next;
                    rpt.run_count  = run_reg;
                    run_next       = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            shift_reg <= '0;
            xor_reg   <= '0;
            type_reg  <= '0;
            err_reg   <= '0;
            run_reg   <= '0;
        end else begin
            pos_reg   <= pos_next;
            shift_reg <= shift_next;
            xor_reg   <= xor_next;
            type_reg  <= type_next;
            err_reg   <= err_next;
            run_reg   <= run_next;
        end
    end

endmodule

// ----- hw/rtl/cvfr_table.sv -----
module cvfr_table #(
    parameter int TYPE_COUNT = cvfr_pkg::TYPE_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cvfr_pkg::table_wr_t wr,
    input  logic                rd_en,
    input  logic [3:0]          rd_index,
    output logic [15:0]         rd_word
);
    import cvfr_pkg::*;

    localparam int ADDR_W = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

    logic [15:0]           mem [TYPE_COUNT];
    logic [TYPE_COUNT-1:0] valid_reg;
    logic [15:0]           rd_data_reg;
    logic                  rd_ok_reg;
    logic [7:0]            rd_index_ext;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  rd_in_range;

    assign rd_index_ext = {4'b0000, rd_index};
    assign rd_addr      = rd_index_ext[ADDR_W-1:0];
    assign wr_addr      = wr.entry[ADDR_W-1:0];
    assign rd_in_range  = ({1'b0, rd_index_ext} < 9'(TYPE_COUNT));

    // Entry storage, one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr_addr] <= wr.data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Written flags: an entry never written reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            if (wr.en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_ok_reg <= rd_in_range && valid_reg[rd_addr];
            end
        end
    end

    assign rd_word = rd_ok_reg ? rd_data_reg : 16'h0000;

endmodule

// ----- hw/rtl/checked_value_frame_receiver.sv -----
// A result passes the second-stage register, then the output register, before m_valid.
// One request per cycle while s_ready is high. Table memory: one write and one read port.
// Frame bytes one to five produce no result and only update the assembly registers.
// Reset (aresetn low, synchronous) clears frame state, error word, run count and the
// table's written flags; no clearing pass follows.
module checked_value_frame_receiver #(
    parameter int TYPE_COUNT = cvfr_pkg::TYPE_COUNT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_rx_byte,
    input  logic [3:0]  s_read_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [1:0]  m_status,
    output logic [7:0]  m_frame_type,
    output logic [15:0] m_stored_value,
    output logic [31:0] m_error_word,
    output logic [7:0]  m_run_count
);
    import cvfr_pkg::*;

    logic        accept;
    logic        byte_en;
    logic        rd_en;
    logic        p2_load;
    logic        p2_move;
    frame_rpt_t  rpt;
    table_wr_t   wr;
    logic [31:0] error_hold;
    logic [15:0] rd_word;

    logic        p2_valid_reg;
    logic        p2_kind_reg;
    logic [1:0]  p2_status_reg;
    logic [7:0]  p2_type_reg;
    logic [15:0] p2_sval_reg;
    logic [31:0] p2_err_reg;
    logic [7:0]  p2_run_reg;

    logic        out_valid_reg;
    logic        out_kind_reg;
    logic [1:0]  out_status_reg;
    logic [7:0]  out_type_reg;
    logic [15:0] out_sval_reg;
    logic [31:0] out_err_reg;
    logic [7:0]  out_run_reg;

    // Request handshake and decode.
    assign p2_move = p2_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !p2_valid_reg || p2_move;
    assign accept  = s_valid && s_ready;
    assign byte_en = accept && (s_op == OP_BYTE);
    assign rd_en   = accept && (s_op == OP_READ);
    assign p2_load = rd_en || rpt.done;

    cvfr_frame #(
        .TYPE_COUNT(TYPE_COUNT)
    ) u_frame (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_en   (byte_en),
        .rx_byte   (s_rx_byte),
        .rpt       (rpt),
        .wr        (wr),
        .error_hold(error_hold)
    );

    cvfr_table #(
        .TYPE_COUNT(TYPE_COUNT)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (wr),
        .rd_en   (rd_en),
        .rd_index(s_read_index),
        .rd_word (rd_word)
    );

    // Second stage: waits for the table read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (p2_load) begin
            p2_valid_reg <= 1'b1;
        end else if (p2_move) begin
            p2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_load) begin
            if (rd_en) begin
                p2_kind_reg   <= KIND_READ;
                p2_status_reg <= ST_STORED;
                p2_type_reg   <= '0;
                p2_sval_reg   <= '0;
                p2_err_reg    <= error_hold;
                p2_run_reg    <= '0;
            end else begin
                p2_kind_reg   <= KIND_FRAME;
                p2_status_reg <= rpt.status;
                p2_type_reg   <= rpt.frame_type;
                p2_sval_reg   <= rpt.stored_value;
                p2_err_reg    <= rpt.error_word;
                p2_run_reg    <= rpt.run_count;
            end
        end
    end

    // Output register toward the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (p2_move) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p2_move) begin
            out_kind_reg   <= p2_kind_reg;
            out_status_reg <= p2_status_reg;
            out_type_reg   <= p2_type_reg;
            out_sval_reg   <= (p2_kind_reg == KIND_READ) ? rd_word : p2_sval_reg;
            out_err_reg    <= p2_err_reg;
            out_run_reg    <= p2_run_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_kind         = out_kind_reg;
    assign m_status       = out_status_reg;
    assign m_frame_type   = out_type_reg;
    assign m_stored_value = out_sval_reg;
    assign m_error_word   = out_err_reg;
    assign m_run_count    = out_run_reg;

endmodule

// ----- dv/tb_top.sv -----
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import cvfr_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_FRAMES = 205;
    localparam int MAX_LOGGED    = 40;

    // One reply of the block, field by field.
    typedef struct packed {
        logic        kind;
        logic [1:0]  status;
        logic [7:0]  frame_type;
        logic [15:0] stored_value;
        logic [31:0] error_word;
        logic [7:0]  run_count;
    } reply_t;

    // One row of the directed table.
    typedef struct {
        logic       op;
        logic [7:0] rx;
        logic [3:0] idx;
        bit         typed;
        reply_t     reply;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_op;
    logic [7:0]  s_rx_byte;
    logic [3:0]  s_read_index;
    logic        m_valid;
    logic        m_ready;
    logic        m_kind;
    logic [1:0]  m_status;
    logic [7:0]  m_frame_type;
    logic [15:0] m_stored_value;
    logic [31:0] m_error_word;
    logic [7:0]  m_run_count;

    // Side band to the checker: a directed request may carry a typed reply.
    bit          req_typed;
    reply_t      req_reply;

    // Receiver state as the testbench sees it.
    logic [2:0]  frame_pos;
    logic [31:0] frame_value;
    logic [7:0]  frame_xor;
    logic [7:0]  frame_type_hold;
    logic [15:0] table_copy [TYPE_COUNT_DEF];
    logic [31:0] error_copy;
    logic [7:0]  run_len;

    reply_t      due_replies [$];
    stim_row_t   directed_rows [$];
    int          fail_count;
    int          cycle_count;
    int          sent_count;
    bit          send_calm;
    bit          take_calm;

    checked_value_frame_receiver dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_op           (s_op),
        .s_rx_byte      (s_rx_byte),
        .s_read_index   (s_read_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_status       (m_status),
        .m_frame_type   (m_frame_type),
        .m_stored_value (m_stored_value),
        .m_error_word   (m_error_word),
        .m_run_count    (m_run_count)
    );

    // 4 ns clock.
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_LOGGED) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    task automatic clear_frame();
        frame_pos       = '0;
        frame_value     = '0;
        frame_xor       = '0;
        frame_type_hold = '0;
    endtask

    // Advance the receiver state by one request and work out its reply, if any.
    task automatic decode_request(input logic op, input logic [7:0] rx,
                                  input logic [3:0] idx, output bit produced,
                                  output reply_t res);
        logic        check_ok;
        logic [7:0]  ftype;
        logic [31:0] word;
        res      = '0;
        produced = 1'b0;
        if (op == OP_READ) begin
            res.kind       = KIND_READ;
            res.error_word = error_copy;
            if (int'(idx) < TYPE_COUNT_DEF) begin
                res.stored_value = table_copy[idx];
            end
            produced = 1'b1;
        end else if (frame_pos < POS_TYPE) begin
            frame_value = {frame_value[23:0], rx};
            frame_xor   = frame_xor ^ rx;
            frame_pos   = frame_pos + 3'd1;
        end else if (frame_pos == POS_TYPE) begin
            frame_type_hold = rx;
            frame_xor       = frame_xor ^ rx;
            frame_pos       = frame_pos + 3'd1;
        end else begin
            // Check byte: finish the frame and report its status.
            check_ok = (frame_xor == rx);
            ftype    = frame_type_hold;
            word     = frame_value;
            clear_frame();
            res.kind       = KIND_FRAME;
            res.frame_type = ftype;
            if (check_ok && int'(ftype) < TYPE_COUNT_DEF) begin
                table_copy[ftype[3:0]] = word[15:0];
                if (run_len != RUN_MAX) begin
                    run_len = run_len + 8'd1;
                end
                res.status       = ST_STORED;
                res.stored_value = word[15:0];
            end else begin
                res.run_count = run_len;
                if (check_ok) begin
                    error_copy = word;
                    res.status = ST_RANGE;
                end else begin
                    error_copy = CHECK_FAIL_WORD;
                    res.status = ST_CHECK;
                end
                run_len = '0;
            end
            res.error_word = error_copy;
            produced       = 1'b1;
        end
    endtask

    // Checker: compare each reply with the oldest one due, then book new requests.
    always @(posedge aclk) begin
        bit     produced;
        reply_t got;
        reply_t want;
        reply_t model;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_kind, m_status, m_frame_type, m_stored_value, m_error_word,
                       m_run_count};
                if (due_replies.size() == 0) begin
                    report_mismatch($sformatf("reply 0x%0h with none due", got));
                end else begin
                    want = due_replies.pop_front();
                    check_field("kind", 32'(got.kind), 32'(want.kind));
                    check_field("status", 32'(got.status), 32'(want.status));
                    check_field("frame_type", 32'(got.frame_type), 32'(want.frame_type));
                    check_field("stored_value", 32'(got.stored_value),
                                32'(want.stored_value));
                    check_field("error_word", got.error_word, want.error_word);
                    check_field("run_count", 32'(got.run_count), 32'(want.run_count));
                end
            end
            if (s_valid && s_ready) begin
                decode_request(s_op, s_rx_byte, s_read_index, produced, model);
                if (produced) begin
                    due_replies.push_back(req_typed ? req_reply : model);
                end
            end
        end
    end

    // Send one request after a drawn gap and wait for its handshake.
    task automatic issue(input logic op, input logic [7:0] rx, input logic [3:0] idx,
                         input bit typed, input reply_t want);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_rx_byte    <= rx;
        s_read_index <= idx;
        req_typed    <= typed;
        req_reply    <= want;
        do @(posedge aclk); while (!(s_valid && s_ready));
        sent_count++;
        if (sent_count % 50 == 0) begin
            send_calm = ($urandom_range(0, 2) == 0);
        end
    endtask

    // Stop sending until every reply due has come back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_replies.size() != 0);
    endtask

    // A frame byte, sometimes preceded by a table read.
    task automatic send_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < 12) begin
            issue(OP_READ, 8'($urandom), 4'($urandom), 1'b0, '0);
        end
        issue(OP_BYTE, b, 4'($urandom), 1'b0, '0);
    endtask

    // A whole frame; a nonzero flip corrupts the check byte.
    task automatic send_frame(input logic [31:0] value, input logic [7:0] ftype,
                              input logic [7:0] flip);
        logic [7:0] chk;
        chk = value[31:24] ^ value[23:16] ^ value[15:8] ^ value[7:0] ^ ftype ^ flip;
        send_byte(value[31:24]);
        send_byte(value[23:16]);
        send_byte(value[15:8]);
        send_byte(value[7:0]);
        send_byte(ftype);
        send_byte(chk);
    endtask

    function automatic logic [31:0] pick_word();
        int w;
        w = $urandom_range(0, 9);
        if (w == 0) begin
            return '0;
        end else if (w == 1) begin
            return '1;
        end
        return $urandom;
    endfunction

    function automatic void add_row(input logic op, input logic [7:0] rx,
                                    input logic [3:0] idx);
        stim_row_t r;
        r.op    = op;
        r.rx    = rx;
        r.idx   = idx;
        r.typed = 1'b0;
        r.reply = '0;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_typed(input logic op, input logic [7:0] rx,
                                      input logic [3:0] idx, input reply_t want);
        stim_row_t r;
        r.op    = op;
        r.rx    = rx;
        r.idx   = idx;
        r.typed = 1'b1;
        r.reply = want;
        directed_rows.push_back(r);
    endfunction

    // Receiver side: stall for a drawn number of cycles before each reply.
    initial begin
        int stall;
        int taken;
        taken     = 0;
        take_calm = 1'b0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = take_calm ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready));
            taken++;
            if (taken % 30 == 0) begin
                take_calm = ($urandom_range(0, 2) == 0);
            end
        end
    end

    // Main sequence: reset, directed table, random frames, drain.
    initial begin
        int seg;
        int w;
        int k;
        stim_row_t r;
        fail_count  = 0;
        sent_count  = 0;
        send_calm   = 1'b0;
        clear_frame();
        foreach (table_copy[i]) table_copy[i] = '0;
        error_copy = '0;
        run_len    = '0;

        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_op         <= OP_BYTE;
        s_rx_byte    <= '0;
        s_read_index <= '0;
        req_typed    <= 1'b0;
        req_reply    <= '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Read straight after reset sees an empty table.
        add_typed(OP_READ, 8'hA5, 4'd0, '{KIND_READ, ST_STORED, 8'h00, 16'h0000,
                  32'h0, 8'h00});
        // Good frame stored at type 3.
        add_row(OP_BYTE, 8'h12, 4'd0);
        add_row(OP_BYTE, 8'h34, 4'd0);
        add_row(OP_BYTE, 8'h56, 4'd0);
        add_row(OP_BYTE, 8'h78, 4'd0);
        add_row(OP_BYTE, 8'h03, 4'd0);
        add_typed(OP_BYTE, 8'h0B, 4'd0, '{KIND_FRAME, ST_STORED, 8'h03, 16'h5678,
                  32'h0, 8'h00});
        // All-ones value at the top entry, with a read in the middle of the frame.
        add_row(OP_BYTE, 8'hFF, 4'd15);
        add_row(OP_BYTE, 8'hFF, 4'd15);
        add_row(OP_BYTE, 8'hFF, 4'd15);
        add_row(OP_BYTE, 8'hFF, 4'd15);
        add_typed(OP_READ, 8'h5A, 4'd15, '{KIND_READ, ST_STORED, 8'h00, 16'h0000,
                  32'h0, 8'h00});
        add_row(OP_BYTE, 8'h0F, 4'd15);
        add_typed(OP_BYTE, 8'h0F, 4'd15, '{KIND_FRAME, ST_STORED, 8'h0F, 16'hFFFF,
                  32'h0, 8'h00});
        // Type out of range ends a run of two stored frames.
        add_row(OP_BYTE, 8'hDE, 4'd0);
        add_row(OP_BYTE, 8'hAD, 4'd0);
        add_row(OP_BYTE, 8'hBE, 4'd0);
        add_row(OP_BYTE, 8'hEF, 4'd0);
        add_row(OP_BYTE, 8'h10, 4'd0);
        add_typed(OP_BYTE, 8'h32, 4'd0, '{KIND_FRAME, ST_RANGE, 8'h10, 16'h0000,
                  32'hDEADBEEF, 8'h02});
        // Checksum mismatch with the largest type byte.
        add_row(OP_BYTE, 8'h00, 4'd0);
        add_row(OP_BYTE, 8'h00, 4'd0);
        add_row(OP_BYTE, 8'h00, 4'd0);
        add_row(OP_BYTE, 8'h00, 4'd0);
        add_row(OP_BYTE, 8'hFF, 4'd0);
        add_typed(OP_BYTE, 8'h00, 4'd0, '{KIND_FRAME, ST_CHECK, 8'hFF, 16'h0000,
                  CHECK_FAIL_WORD, 8'h00});
        // Stored word survives the failed frames.
        add_typed(OP_READ, 8'h00, 4'd3, '{KIND_READ, ST_STORED, 8'h00, 16'h5678,
                  CHECK_FAIL_WORD, 8'h00});

        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            issue(r.op, r.rx, r.idx, r.typed, r.reply);
        end

        // Random frames: mostly well formed, some out of range, corrupt or noise.
        for (seg = 0; seg < RANDOM_FRAMES; seg++) begin
            if (seg == 120) begin
                wait_drained();
            end
            w = $urandom_range(0, 99);
            if (w < 65) begin
                send_frame(pick_word(), 8'($urandom_range(0, TYPE_COUNT_DEF - 1)), 8'h00);
            end else if (w < 75) begin
                send_frame(pick_word(), 8'($urandom_range(TYPE_COUNT_DEF, 255)), 8'h00);
            end else if (w < 85) begin
                send_frame(pick_word(), 8'($urandom), 8'($urandom_range(1, 255)));
            end else if (w < 95) begin
                for (k = 0; k < 6; k++) begin
                    send_byte(8'($urandom));
                end
            end else begin
                wait_drained();
                send_frame(pick_word(), 8'($urandom_range(0, TYPE_COUNT_DEF - 1)), 8'h00);
            end
        end

        // Let the last replies come back, then allow for the pipeline.
        wait_drained();
        repeat (10) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
